FILE: rtl/core/stkps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stkps_pkg
// Shared types and constants of the scored top-k peer select core.
// ----------------------------------------------------------------------------
package stkps_pkg;

  // Widths fixed by the record formats
  localparam int KEY_W        = 64;
  localparam int WORD_W       = 32;
  localparam int SCORE_W      = 17;
  localparam int LIMIT_W      = 5;
  localparam int FOUND_W      = 5;

  // Default list depth and reset value of the limit register
  localparam int               MAX_KEEP_DEF = 16;
  localparam logic [LIMIT_W-1:0] LIMIT_RST  = 5'd16;

  // Score terms
  localparam int SCORE_BASE = 100000;
  localparam int OK_CAP     = 50;
  localparam int OK_CAP_W   = 6;
  localparam int SUM_W      = 18;

  // Divide by 1000 as multiply by reciprocal: q = (avg * DIV_MUL) >> DIV_SHIFT,
  // exact for every 32-bit avg.
  localparam logic [WORD_W-1:0] DIV_MUL   = 32'd2199023256;
  localparam int                DIV_SHIFT = 41;
  localparam int                PROD_W    = 2 * WORD_W;
  localparam int                Q_W       = PROD_W - DIV_SHIFT;

  // One input transaction
  typedef struct packed {
    logic [KEY_W-1:0]  peer_key_hi;
    logic [KEY_W-1:0]  peer_key_lo;
    logic [KEY_W-1:0]  service_bits;
    logic [WORD_W-1:0] handshake_usec;
    logic [WORD_W-1:0] ok_count;
    logic [WORD_W-1:0] fail_count;
    logic [WORD_W-1:0] avg_chunk_usec;
    logic              last_entry;
  } in_t;

  // One output transaction
  typedef struct packed {
    logic               result_valid;
    logic [KEY_W-1:0]   best_key_hi;
    logic [KEY_W-1:0]   best_key_lo;
    logic [KEY_W-1:0]   best_services;
    logic [WORD_W-1:0]  best_latency_usec;
    logic [WORD_W-1:0]  best_ok_count;
    logic [WORD_W-1:0]  best_fail_count;
    logic [WORD_W-1:0]  best_avg_chunk;
    logic [SCORE_W-1:0] best_score;
    logic               last_result;
    logic [FOUND_W-1:0] found_count;
  } out_t;

  // Scored record as held in one list slot
  typedef struct packed {
    logic [KEY_W-1:0]   key_hi;
    logic [KEY_W-1:0]   key_lo;
    logic [KEY_W-1:0]   services;
    logic [WORD_W-1:0]  latency;
    logic [WORD_W-1:0]  ok;
    logic [WORD_W-1:0]  fail;
    logic [WORD_W-1:0]  avg_chunk;
    logic [SCORE_W-1:0] score;
  } slot_t;

  // Per-cell control from the list controller
  typedef struct packed {
    logic occupied;
    logic insert;
    logic shift_down;
  } cell_ctl_t;

  // Status of the scoring pipeline
  typedef struct packed {
    logic valid;
    logic keep;
    logic last;
    logic pend_last;
  } scr_stat_t;

endpackage

FILE: rtl/core/stkps_score.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stkps_score
// Two-stage scoring pipeline: reciprocal multiply, then score and reject test.
// ----------------------------------------------------------------------------
module stkps_score (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  stkps_pkg::in_t     in_data,
  output stkps_pkg::slot_t   rec,
  output stkps_pkg::scr_stat_t stat
);
  import stkps_pkg::*;

  logic              s1_valid;
  in_t               s1_data;
  logic [Q_W-1:0]    s1_q;
  logic [PROD_W-1:0] prod;

  logic              s2_valid;
  logic              s2_keep;
  logic              s2_last;
  slot_t             s2_rec;

  logic [OK_CAP_W-1:0] ok_cap;
  logic [SUM_W-1:0]    sum;
  logic [Q_W-1:0]      diff;
  logic                keep;
  logic [SCORE_W-1:0]  score;

  // Divide average chunk time by 1000
  assign prod = PROD_W'(in_data.avg_chunk_usec) * PROD_W'(DIV_MUL);

  // Stage 1: register transaction and quotient
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
    if (accept) begin
      s1_data <= in_data;
      s1_q    <= prod[PROD_W-1:DIV_SHIFT];
    end
  end

  // Score: base minus quotient plus capped success count, 1 for a zero average
  always_comb begin
    ok_cap = (s1_data.ok_count < WORD_W'(OK_CAP)) ? s1_data.ok_count[OK_CAP_W-1:0]
                                                  : OK_CAP_W'(OK_CAP);
    sum    = SUM_W'(SCORE_BASE) + SUM_W'(ok_cap);
    diff   = Q_W'(sum) - s1_q;
    keep   = 1'b0;
    score  = '0;
    if (s1_data.fail_count == '0 && s1_data.ok_count != '0) begin
      if (s1_data.avg_chunk_usec == '0) begin
        keep  = 1'b1;
        score = SCORE_W'(1);
      end else if (Q_W'(sum) > s1_q) begin
        keep  = 1'b1;
        score = diff[SCORE_W-1:0];
      end
    end
  end

  // Stage 2: register scored record
  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else begin
      s2_valid <= s1_valid;
    end
    if (s1_valid) begin
      s2_keep          <= keep;
      s2_last          <= s1_data.last_entry;
      s2_rec.key_hi    <= s1_data.peer_key_hi;
      s2_rec.key_lo    <= s1_data.peer_key_lo;
      s2_rec.services  <= s1_data.service_bits;
      s2_rec.latency   <= s1_data.handshake_usec;
      s2_rec.ok        <= s1_data.ok_count;
      s2_rec.fail      <= s1_data.fail_count;
      s2_rec.avg_chunk <= s1_data.avg_chunk_usec;
      s2_rec.score     <= score;
    end
  end

  assign rec            = s2_rec;
  assign stat.valid     = s2_valid;
  assign stat.keep      = s2_keep;
  assign stat.last      = s2_last;
  assign stat.pend_last = (s1_valid && s1_data.last_entry) || (s2_valid && s2_last);

endmodule

FILE: rtl/core/stkps_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stkps_cell
// One slot of the sorted list: compares against the incoming score, shifts
// up on insertion and down on emission.
// ----------------------------------------------------------------------------
module stkps_cell (
  input  logic                 clk,
  input  stkps_pkg::cell_ctl_t ctl,
  input  stkps_pkg::slot_t     new_rec,
  input  stkps_pkg::slot_t     left_rec,
  input  logic                 left_ge,
  input  stkps_pkg::slot_t     right_rec,
  output stkps_pkg::slot_t     rec,
  output logic                 ge
);
  import stkps_pkg::*;

  slot_t slot;

  // Kept entry stays ahead of the new one on equal score
  assign ge  = ctl.occupied && (slot.score >= new_rec.score);
  assign rec = slot;

  // Shift down on emission; on insertion take from left or take new record
  always_ff @(posedge clk) begin
    if (ctl.shift_down) begin
      slot <= right_rec;
    end else if (ctl.insert) begin
      if (!left_ge) begin
        slot <= left_rec;
      end else if (!ge) begin
        slot <= new_rec;
      end
    end
  end

endmodule

FILE: rtl/core/scored_top_k_peer_select_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scored_top_k_peer_select_core
// Keeps the best-scoring peer records in a sorted chain of slot cells and
// emits them best-first when the last record of a run arrives.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_data) takes one peer record per
//   transaction, one per cycle while no run is being closed or emitted.
//   Each record is scored in a two-stage pipeline, then inserted into the
//   cell chain: every cell compares its score with the new one and shifts
//   in the same cycle. A record with last_entry set closes the run: in_stall
//   rises the cycle after it is taken and stays high until the last result
//   is in the output register. Output channel (out_valid / out_stall /
//   out_data) then carries one transaction per kept record, best first, or
//   one with result_valid low if nothing was kept. The first result is loaded
//   once the last record has passed both scoring stages and emission has
//   begun; results follow one per cycle while out_stall is low, and a stalled
//   result holds in the output register. The input stays stalled through the
//   whole emission, which shifts the chain one slot toward its head per
//   result and lasts longer while out_stall holds a result.
//   Config channel (cfg_valid / cfg_ready / cfg_data) writes keep_limit;
//   it is always ready. Reset empties the list and sets keep_limit to 16.
// ----------------------------------------------------------------------------
module scored_top_k_peer_select_core #(
  parameter int MAX_KEEP = stkps_pkg::MAX_KEEP_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  stkps_pkg::in_t                in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output stkps_pkg::out_t               out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [stkps_pkg::LIMIT_W-1:0] cfg_data
);
  import stkps_pkg::*;

  localparam int CNT_W = $clog2(MAX_KEEP + 1);

  logic [LIMIT_W-1:0] keep_limit;
  logic [CNT_W-1:0]   limit;
  logic [CNT_W-1:0]   kept_count;
  logic [CNT_W-1:0]   kept_count_next;
  logic [CNT_W-1:0]   found;
  logic [CNT_W-1:0]   emit_left;
  logic               emitting;
  logic               accept;
  logic               take;
  logic               last_ge;
  logic               load;
  out_t               out_reg;
  out_t               empty_out;

  slot_t              new_rec;
  scr_stat_t          stat;
  slot_t              cell_rec [MAX_KEEP];
  logic [MAX_KEEP-1:0] ge;

  // Accept while no run is closing or being emitted
  assign in_stall  = emitting || stat.pend_last;
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;

  // Limit register
  always_ff @(posedge clk) begin
    if (rst) begin
      keep_limit <= LIMIT_RST;
    end else if (cfg_valid) begin
      keep_limit <= cfg_data;
    end
  end

  assign limit = (32'(keep_limit) > MAX_KEEP) ? CNT_W'(MAX_KEEP) : CNT_W'(keep_limit);

  stkps_score u_score (
    .clk     (clk),
    .rst     (rst),
    .accept  (accept),
    .in_data (in_data),
    .rec     (new_rec),
    .stat    (stat)
  );

  // Pick the compare result of the last slot inside the limit
  always_comb begin
    last_ge = 1'b0;
    for (int i = 0; i < MAX_KEEP; i++) begin
      if (CNT_W'(i + 1) == limit) begin
        last_ge = ge[i];
      end
    end
  end

  // Decide whether the scored record enters the list
  always_comb begin
    take = stat.valid && stat.keep && (limit != '0) &&
           ((kept_count < limit) || !last_ge);
    kept_count_next = kept_count;
    if (take && kept_count < limit) begin
      kept_count_next = kept_count + CNT_W'(1);
    end
  end

  // Cell chain
  for (genvar i = 0; i < MAX_KEEP; i++) begin : g_cell
    cell_ctl_t ctl;
    slot_t     left_rec;
    slot_t     right_rec;
    logic      left_ge;

    assign ctl.occupied   = kept_count > CNT_W'(i);
    assign ctl.insert     = take && (limit > CNT_W'(i)) && (kept_count >= CNT_W'(i));
    assign ctl.shift_down = load && (found != '0);

    if (i == 0) begin : g_head
      assign left_rec = new_rec;
      assign left_ge  = 1'b1;
    end else begin : g_body
      assign left_rec = cell_rec[i-1];
      assign left_ge  = ge[i-1];
    end

    if (i == MAX_KEEP - 1) begin : g_tail
      assign right_rec = cell_rec[i];
    end else begin : g_mid
      assign right_rec = cell_rec[i+1];
    end

    stkps_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .new_rec   (new_rec),
      .left_rec  (left_rec),
      .left_ge   (left_ge),
      .right_rec (right_rec),
      .rec       (cell_rec[i]),
      .ge        (ge[i])
    );
  end

  // Load the output register while emitting and it is free
  assign load = emitting && (!out_valid || !out_stall);

  // Run control: count, emission start and advance
  always_ff @(posedge clk) begin
    if (rst) begin
      kept_count <= '0;
      emitting   <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (stat.valid && stat.last) begin
        kept_count <= '0;
        emitting   <= 1'b1;
      end else begin
        kept_count <= kept_count_next;
      end
      if (load) begin
        out_valid <= 1'b1;
        if (found == '0 || emit_left == CNT_W'(1)) begin
          emitting <= 1'b0;
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Latch run size; step down per emitted result
  always_ff @(posedge clk) begin
    if (stat.valid && stat.last) begin
      found     <= kept_count_next;
      emit_left <= kept_count_next;
    end else if (load && found != '0) begin
      emit_left <= emit_left - CNT_W'(1);
    end
  end

  // Marker for a run that kept nothing
  always_comb begin
    empty_out             = '0;
    empty_out.last_result = 1'b1;
  end

  // Output payload from the head cell, or the empty-list marker
  always_ff @(posedge clk) begin
    if (load) begin
      if (found == '0) begin
        out_reg <= empty_out;
      end else begin
        out_reg.result_valid      <= 1'b1;
        out_reg.best_key_hi       <= cell_rec[0].key_hi;
        out_reg.best_key_lo       <= cell_rec[0].key_lo;
        out_reg.best_services     <= cell_rec[0].services;
        out_reg.best_latency_usec <= cell_rec[0].latency;
        out_reg.best_ok_count     <= cell_rec[0].ok;
        out_reg.best_fail_count   <= cell_rec[0].fail;
        out_reg.best_avg_chunk    <= cell_rec[0].avg_chunk;
        out_reg.best_score        <= cell_rec[0].score;
        out_reg.last_result       <= (emit_left == CNT_W'(1));
        out_reg.found_count       <= FOUND_W'(found);
      end
    end
  end

  assign out_data = out_reg;

endmodule

FILE: dv/scored_top_k_peer_select_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scored_top_k_peer_select_core_tb
// Self-checking bench for the top-k peer select core. A queue-fed driver
// streams peer records in random bursts. A ranking model scores each accepted
// record and keeps its own best-first list. On each closing record it queues
// the list it expects to be handed out. A monitor compares every output
// transaction field by field. The output side stalls on shifting patterns,
// with one long hold-off once five runs have closed. The list depth limit
// is changed while idle, also mid-run, including a drop below the current fill.
// ----------------------------------------------------------------------------
module scored_top_k_peer_select_core_tb;
  import stkps_pkg::*;

  localparam int LIST_DEPTH  = MAX_KEEP_DEF;
  localparam int RANDOM_RECS = 135;
  localparam int SETTLE      = 8;
  localparam int HOLD_CYCLES = 400;
  localparam int CYCLE_LIMIT = 200000;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  in_t                in_data = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  out_t               out_data;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [LIMIT_W-1:0] cfg_data = '0;

  scored_top_k_peer_select_core dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // 8 ns clock
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Records waiting to be sent, and results the ranking model has produced
  in_t  record_feed[$];
  out_t due_results[$];

  // Ranking model state
  logic [LIMIT_W-1:0] model_limit = LIMIT_RST;
  slot_t              ranked[LIST_DEPTH];
  int                 ranked_count = 0;

  int error_count  = 0;
  int runs_closed  = 0;
  int cycle_count  = 0;

  // Score a record; 0 means rejected
  function automatic logic [SCORE_W-1:0] score_of(logic [WORD_W-1:0] ok,
                                                  logic [WORD_W-1:0] fail,
                                                  logic [WORD_W-1:0] avg);
    longint s;
    if (fail != 0 || ok == 0) return '0;
    if (avg == 0) return SCORE_W'(1);
    s = longint'(SCORE_BASE) - longint'(avg / 1000) + longint'((ok < OK_CAP) ? ok : OK_CAP);
    return (s > 0) ? s[SCORE_W-1:0] : '0;
  endfunction

  // Insert an accepted record into the model list; on the closing record
  // queue the whole list best-first and empty it
  function automatic void rank_record(in_t r);
    logic [SCORE_W-1:0] sc;
    int                 lim;
    int                 pos;
    bit                 take;
    out_t               o;
    sc   = score_of(r.ok_count, r.fail_count, r.avg_chunk_usec);
    lim  = (model_limit > LIST_DEPTH) ? LIST_DEPTH : model_limit;
    take = 1'b0;
    pos  = 0;
    if (sc != 0 && lim != 0) begin
      if (ranked_count < lim) begin
        take = 1'b1;
        pos  = ranked_count;
        ranked_count++;
      end else if (ranked[lim-1].score < sc) begin
        take = 1'b1;
        pos  = lim - 1;
      end
    end
    if (take) begin
      // ties stay ahead: move only strictly lower scores down
      while (pos > 0 && ranked[pos-1].score < sc) begin
        ranked[pos] = ranked[pos-1];
        pos--;
      end
      ranked[pos].key_hi    = r.peer_key_hi;
      ranked[pos].key_lo    = r.peer_key_lo;
      ranked[pos].services  = r.service_bits;
      ranked[pos].latency   = r.handshake_usec;
      ranked[pos].ok        = r.ok_count;
      ranked[pos].fail      = r.fail_count;
      ranked[pos].avg_chunk = r.avg_chunk_usec;
      ranked[pos].score     = sc;
    end
    if (!r.last_entry) return;
    if (ranked_count == 0) begin
      o = '0;
      o.last_result = 1'b1;
      due_results.push_back(o);
    end else begin
      for (int k = 0; k < ranked_count; k++) begin
        o.result_valid      = 1'b1;
        o.best_key_hi       = ranked[k].key_hi;
        o.best_key_lo       = ranked[k].key_lo;
        o.best_services     = ranked[k].services;
        o.best_latency_usec = ranked[k].latency;
        o.best_ok_count     = ranked[k].ok;
        o.best_fail_count   = ranked[k].fail;
        o.best_avg_chunk    = ranked[k].avg_chunk;
        o.best_score        = ranked[k].score;
        o.last_result       = (k + 1 == ranked_count);
        o.found_count       = FOUND_W'(ranked_count);
        due_results.push_back(o);
      end
    end
    ranked_count = 0;
  endfunction

  function automatic void check_field(string name, logic [KEY_W-1:0] want,
                                      logic [KEY_W-1:0] got);
    if (want !== got) begin
      $error("%s: expected %h, got %h", name, want, got);
      error_count++;
    end
  endfunction

  // Compare output transactions and feed the model with input transactions
  always @(posedge clk) begin
    out_t want;
    if (!rst) begin
      if (out_valid && !out_stall) begin
        if (due_results.size() == 0) begin
          $error("unexpected result transaction: %p", out_data);
          error_count++;
        end else begin
          want = due_results.pop_front();
          check_field("result_valid", want.result_valid, out_data.result_valid);
          check_field("best_key_hi", want.best_key_hi, out_data.best_key_hi);
          check_field("best_key_lo", want.best_key_lo, out_data.best_key_lo);
          check_field("best_services", want.best_services, out_data.best_services);
          check_field("best_latency_usec", want.best_latency_usec,
                      out_data.best_latency_usec);
          check_field("best_ok_count", want.best_ok_count, out_data.best_ok_count);
          check_field("best_fail_count", want.best_fail_count, out_data.best_fail_count);
          check_field("best_avg_chunk", want.best_avg_chunk, out_data.best_avg_chunk);
          check_field("best_score", want.best_score, out_data.best_score);
          check_field("last_result", want.last_result, out_data.last_result);
          check_field("found_count", want.found_count, out_data.found_count);
        end
      end
      if (cfg_valid && cfg_ready) model_limit = cfg_data;
      if (in_valid && !in_stall) begin
        rank_record(in_data);
        if (in_data.last_entry) runs_closed++;
      end
    end
  end

  // Driver: bursts of records separated by random gaps
  int burst_left = 0;
  int gap_left   = 0;

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (record_feed.size() > 0) begin
        in_data  <= record_feed.pop_front();
        in_valid <= 1'b1;
        if (burst_left > 0) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 20);
          gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
        end
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Receiver: stall patterns, plus one long hold-off once five runs have closed
  // and more records are still being offered
  int  hold_left    = 0;
  bit  hold_done    = 1'b0;
  int  pattern_left = 0;
  int  pattern_kind = 0;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (!hold_done && runs_closed >= 5 && record_feed.size() != 0) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
      out_stall <= 1'b1;
    end else begin
      if (pattern_left == 0) begin
        pattern_kind = $urandom_range(0, 2);
        pattern_left = $urandom_range(5, 60);
      end
      pattern_left--;
      case (pattern_kind)
        0: begin
          out_stall <= 1'b0;
        end
        1: begin
          out_stall <= ($urandom_range(0, 3) == 0);
        end
        default: begin
          out_stall <= ($urandom_range(0, 3) != 0);
        end
      endcase
    end
  end

  // Abort a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("scored_top_k_peer_select_core_tb NOT OK");
      $finish;
    end
  end

  // Record with random identity and the given counters
  function automatic in_t make_record(logic [WORD_W-1:0] ok, logic [WORD_W-1:0] fail,
                                      logic [WORD_W-1:0] avg, bit last);
    in_t r;
    r.peer_key_hi    = {$urandom, $urandom};
    r.peer_key_lo    = {$urandom, $urandom};
    r.service_bits   = {$urandom, $urandom};
    r.handshake_usec = $urandom;
    r.ok_count       = ok;
    r.fail_count     = fail;
    r.avg_chunk_usec = avg;
    r.last_entry     = last;
    return r;
  endfunction

  // Mostly scoring records with close scores and frequent ties, some rejects
  function automatic in_t random_record(bit last);
    logic [WORD_W-1:0] ok;
    logic [WORD_W-1:0] fail;
    logic [WORD_W-1:0] avg;
    fail = '0;
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4, 5: begin
        ok  = $urandom_range(40, 60);
        avg = 1000 * $urandom_range(0, 10) + $urandom_range(0, 999);
      end
      6: begin
        ok  = $urandom;
        avg = $urandom_range(0, 300000);
      end
      7: begin
        ok  = $urandom_range(1, 5);
        avg = $urandom_range(0, 1) ? '0 : $urandom;
      end
      8: begin
        ok   = $urandom;
        fail = $urandom;
        avg  = $urandom;
      end
      default: begin
        ok  = '0;
        avg = $urandom;
      end
    endcase
    if (fail == 0 && ok == 0 && $urandom_range(0, 1)) fail = 1;
    return make_record(ok, fail, avg, last);
  endfunction

  // Wait until nothing is in flight, then let the core settle
  task automatic wait_idle();
    do @(posedge clk);
    while (record_feed.size() != 0 || in_valid || due_results.size() != 0);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_limit(logic [LIMIT_W-1:0] value);
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    do @(posedge clk);
    while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  initial begin
    in_t              r;
    int               sent;
    int               run_len;
    int               cfg_step;
    logic [LIMIT_W-1:0] lim;

    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty list: a rejected closing record gives one invalid result
    record_feed.push_back(make_record(7, 5, 3000, 1'b1));

    // Scoring corners at the reset limit
    record_feed.push_back(make_record(0, 0, 500, 1'b0));
    r = make_record(3, 0, 0, 1'b0);
    r.peer_key_hi = '0;
    r.peer_key_lo = '0;
    r.service_bits = '0;
    r.handshake_usec = '0;
    record_feed.push_back(r);
    r = make_record('1, 0, 999, 1'b0);
    r.peer_key_hi = '1;
    r.peer_key_lo = '1;
    r.service_bits = '1;
    r.handshake_usec = '1;
    record_feed.push_back(r);
    record_feed.push_back(make_record(1, 0, 100000000, 1'b0));
    record_feed.push_back(make_record(1, 0, 100001000, 1'b0));
    record_feed.push_back(make_record(1, 0, '1, 1'b0));
    record_feed.push_back(make_record(20, 0, 5000, 1'b0));
    record_feed.push_back(make_record(20, 0, 5999, 1'b0));
    record_feed.push_back(make_record(50, 0, 2000, 1'b1));
    wait_idle();

    // Full list: weaker and tied records are dropped, a stronger one displaces
    write_limit(2);
    record_feed.push_back(make_record(10, 0, 3000, 1'b0));
    record_feed.push_back(make_record(10, 0, 1000, 1'b0));
    record_feed.push_back(make_record(10, 0, 4000, 1'b0));
    record_feed.push_back(make_record(9, 0, 2000, 1'b0));
    record_feed.push_back(make_record(30, 0, 1000, 1'b0));
    record_feed.push_back(make_record(5, 1, 1000, 1'b1));
    wait_idle();

    // Lower the limit below the current fill, then close the run
    write_limit(16);
    for (int i = 0; i < 5; i++) record_feed.push_back(make_record(10 + i, 0, 9000, 1'b0));
    wait_idle();
    write_limit(2);
    record_feed.push_back(make_record(50, 0, 1000, 1'b0));
    record_feed.push_back(make_record(1, 0, 90000, 1'b0));
    record_feed.push_back(make_record(2, 0, 0, 1'b1));
    wait_idle();

    // Zero limit rejects everything
    write_limit(0);
    record_feed.push_back(make_record(50, 0, 1000, 1'b0));
    record_feed.push_back(make_record(50, 0, 1000, 1'b1));
    wait_idle();

    // Random runs, changing the limit now and then
    sent = 0;
    cfg_step = 0;
    while (sent < RANDOM_RECS) begin
      if ($urandom_range(0, 2) == 0 || cfg_step < 3) begin
        wait_idle();
        case (cfg_step)
          0: lim = 31;
          1: lim = 1;
          2: lim = 16;
          default: begin
            case ($urandom_range(0, 3))
              0: lim = $urandom_range(0, 31);
              1: lim = $urandom_range(1, 4);
              default: lim = $urandom_range(1, 16);
            endcase
          end
        endcase
        cfg_step++;
        write_limit(lim);
      end
      run_len = ($urandom_range(0, 4) == 0) ? 1 : $urandom_range(2, 24);
      for (int i = 0; i < run_len; i++) begin
        // leave some runs open so the next limit applies to a partial list
        record_feed.push_back(random_record(i == run_len - 1 && $urandom_range(0, 5) != 0));
        sent++;
      end
    end
    record_feed.push_back(random_record(1'b1));

    wait_idle();
    repeat (20) @(posedge clk);
    if (error_count == 0) begin
      $display("scored_top_k_peer_select_core_tb OK");
    end else begin
      $display("scored_top_k_peer_select_core_tb NOT OK");
    end
    $finish;
  end

endmodule
